// ===== sv/mcf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the min-cost flow engine.
// No dependencies; used by every module of the block but mcf_ram.
package mcf_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_ARCS  = 4096;
    localparam int NODE_W    = 10;
    localparam int ARC_AW    = 12;
    localparam int ARC_W     = 13;
    localparam int RES_W     = 16;
    localparam int WGT_W     = 17;
    localparam int DIST_W    = 32;
    localparam int CNT_W     = NODE_W + 1;
    localparam int POP_W     = 2 * NODE_W + 1;
    localparam int STEP_W    = NODE_W + 1;
    localparam int PUSH_W    = 27;
    localparam int UNIT_W    = 16;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 48;

    localparam logic [ARC_W-1:0]  NO_ARC     = '1;
    localparam logic [DIST_W-1:0] DIST_INF   = 32'h003f_3f3f;
    localparam logic [PUSH_W-1:0] UNIT_LAST  = PUSH_W'((MAX_ARCS / 2) * 65535 - 1);
    localparam logic [ARC_W-1:0]  ADD_FULL_AT = ARC_W'(MAX_ARCS - 1);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_SOLVE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        C_NOP, C_LATCH, C_SWEEP, C_ADD_RA, C_ADD_WA, C_ADD_RB, C_ADD_WB,
        C_SOLVE_INIT, C_SR_CLR, C_SR_SRC, C_POP, C_U, C_U2, C_ARC_RD, C_A2,
        C_RELAX, C_DRAIN_RD, C_DRAIN_WR, C_END_RD, C_AUG_RD, C_AUG_P,
        C_CHK_RD, C_CHK_PRED, C_CHK_NEXT, C_PW_RD, C_PW_DEC, C_PW_INC,
        C_UNIT, C_RES_SOLVE, C_RES_FULL
    } cmd_t;

    typedef struct packed {
        logic [ARC_W-1:0]  link;
        logic [WGT_W-1:0]  weight;
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] tail;
    } arc_t;

    typedef struct packed {
        action_t act;
        logic    sweep_last;
        logic    srclr_last;
        logic    add_full;
        logic    src_eq_snk;
        logic    fifo_empty;
        logic    pop_over;
        logic    arc_end;
        logic    snk_reached;
        logic    pred_none;
        logic    a_none;
        logic    chain_bad;
        logic    unit_last;
        logic    out_busy;
    } stat_t;

endpackage

// ===== sv/mcf_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mcf_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/mcf_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the min-cost flow engine: issues one datapath command a cycle.
// Depends on mcf_pkg.
module mcf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  mcf_pkg::stat_t st,
    output mcf_pkg::cmd_t cmd
);

    typedef enum logic [33:0] {
        S_SWEEP  = 34'd1 << 0,
        S_IDLE   = 34'd1 << 1,
        S_DISP   = 34'd1 << 2,
        S_ADD_RA = 34'd1 << 3,
        S_ADD_WA = 34'd1 << 4,
        S_ADD_RB = 34'd1 << 5,
        S_ADD_WB = 34'd1 << 6,
        S_SOLVE  = 34'd1 << 7,
        S_SR_CLR = 34'd1 << 8,
        S_SR_SRC = 34'd1 << 9,
        S_POP    = 34'd1 << 10,
        S_U      = 34'd1 << 11,
        S_U2     = 34'd1 << 12,
        S_ARC    = 34'd1 << 13,
        S_A2     = 34'd1 << 14,
        S_A3     = 34'd1 << 15,
        S_DRAIN  = 34'd1 << 16,
        S_DR2    = 34'd1 << 17,
        S_END    = 34'd1 << 18,
        S_END2   = 34'd1 << 19,
        S_AUG    = 34'd1 << 20,
        S_AUGP   = 34'd1 << 21,
        S_CHK    = 34'd1 << 22,
        S_CHK2   = 34'd1 << 23,
        S_CHK3   = 34'd1 << 24,
        S_PWA    = 34'd1 << 25,
        S_PWP    = 34'd1 << 26,
        S_PW     = 34'd1 << 27,
        S_PW2    = 34'd1 << 28,
        S_PW3    = 34'd1 << 29,
        S_PW4    = 34'd1 << 30,
        S_UNIT   = 34'd1 << 31,
        S_RES    = 34'd1 << 32,
        S_FULL   = 34'd1 << 33
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = mcf_pkg::C_NOP;
        s_tready   = 1'b0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd = mcf_pkg::C_SWEEP;
                if (st.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd        = mcf_pkg::C_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (st.act)
                    mcf_pkg::ACT_CLEAR: state_next = S_SWEEP;
                    mcf_pkg::ACT_ADD:   state_next = st.add_full ? S_FULL : S_ADD_RA;
                    mcf_pkg::ACT_SOLVE: state_next = S_SOLVE;
                    default:            state_next = S_IDLE;
                endcase
            end
            S_ADD_RA:
            begin
                cmd        = mcf_pkg::C_ADD_RA;
                state_next = S_ADD_WA;
            end
            S_ADD_WA:
            begin
                cmd        = mcf_pkg::C_ADD_WA;
                state_next = S_ADD_RB;
            end
            S_ADD_RB:
            begin
                cmd        = mcf_pkg::C_ADD_RB;
                state_next = S_ADD_WB;
            end
            S_ADD_WB:
            begin
                cmd        = mcf_pkg::C_ADD_WB;
                state_next = S_IDLE;
            end
            S_SOLVE:
            begin
                cmd        = mcf_pkg::C_SOLVE_INIT;
                state_next = st.src_eq_snk ? S_RES : S_SR_CLR;
            end
            S_SR_CLR:
            begin
                cmd = mcf_pkg::C_SR_CLR;
                if (st.srclr_last)
                begin
                    state_next = S_SR_SRC;
                end
            end
            S_SR_SRC:
            begin
                cmd        = mcf_pkg::C_SR_SRC;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (st.fifo_empty)
                begin
                    state_next = S_END;
                end
                else if (st.pop_over)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd        = mcf_pkg::C_POP;
                    state_next = S_U;
                end
            end
            S_U:
            begin
                cmd        = mcf_pkg::C_U;
                state_next = S_U2;
            end
            S_U2:
            begin
                cmd        = mcf_pkg::C_U2;
                state_next = S_ARC;
            end
            S_ARC:
            begin
                if (st.arc_end)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd        = mcf_pkg::C_ARC_RD;
                    state_next = S_A2;
                end
            end
            S_A2:
            begin
                cmd        = mcf_pkg::C_A2;
                state_next = S_A3;
            end
            S_A3:
            begin
                cmd        = mcf_pkg::C_RELAX;
                state_next = S_ARC;
            end
            S_DRAIN:
            begin
                if (st.fifo_empty)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    cmd        = mcf_pkg::C_DRAIN_RD;
                    state_next = S_DR2;
                end
            end
            S_DR2:
            begin
                cmd        = mcf_pkg::C_DRAIN_WR;
                state_next = S_DRAIN;
            end
            S_END:
            begin
                cmd        = mcf_pkg::C_END_RD;
                state_next = S_END2;
            end
            S_END2:
            begin
                state_next = st.snk_reached ? S_AUG : S_RES;
            end
            S_AUG:
            begin
                cmd        = mcf_pkg::C_AUG_RD;
                state_next = S_AUGP;
            end
            S_AUGP:
            begin
                cmd        = mcf_pkg::C_AUG_P;
                state_next = st.pred_none ? S_RES : S_CHK;
            end
            S_CHK:
            begin
                if (st.a_none)
                begin
                    state_next = S_PWA;
                end
                else if (st.chain_bad)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    cmd        = mcf_pkg::C_CHK_RD;
                    state_next = S_CHK2;
                end
            end
            S_CHK2:
            begin
                cmd        = mcf_pkg::C_CHK_PRED;
                state_next = S_CHK3;
            end
            S_CHK3:
            begin
                cmd        = mcf_pkg::C_CHK_NEXT;
                state_next = S_CHK;
            end
            S_PWA:
            begin
                cmd        = mcf_pkg::C_AUG_RD;
                state_next = S_PWP;
            end
            S_PWP:
            begin
                cmd        = mcf_pkg::C_AUG_P;
                state_next = S_PW;
            end
            S_PW:
            begin
                if (st.a_none)
                begin
                    state_next = S_UNIT;
                end
                else
                begin
                    cmd        = mcf_pkg::C_PW_RD;
                    state_next = S_PW2;
                end
            end
            S_PW2:
            begin
                cmd        = mcf_pkg::C_PW_DEC;
                state_next = S_PW3;
            end
            S_PW3:
            begin
                cmd        = mcf_pkg::C_PW_INC;
                state_next = S_PW4;
            end
            S_PW4:
            begin
                cmd        = mcf_pkg::C_CHK_NEXT;
                state_next = S_PW;
            end
            S_UNIT:
            begin
                cmd        = mcf_pkg::C_UNIT;
                state_next = st.unit_last ? S_RES : S_SR_CLR;
            end
            S_RES:
            begin
                if (!st.out_busy)
                begin
                    cmd        = mcf_pkg::C_RES_SOLVE;
                    state_next = S_IDLE;
                end
            end
            S_FULL:
            begin
                if (!st.out_busy)
                begin
                    cmd        = mcf_pkg::C_RES_FULL;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/mcf_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the min-cost flow engine: graph stores, search queue, totals.
// Depends on mcf_pkg and mcf_ram.
module mcf_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mcf_pkg::cmd_t                   cmd,
    output mcf_pkg::stat_t                  st,
    input  logic [mcf_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mcf_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [0:0]                      m_tuser
);

    localparam int NW = mcf_pkg::NODE_W;
    localparam int AW = mcf_pkg::ARC_AW;
    localparam int XW = mcf_pkg::ARC_W;
    localparam logic [mcf_pkg::CNT_W-1:0] CNT_ONE = mcf_pkg::CNT_W'(1);

    // latched item and working registers
    mcf_pkg::action_t              act_reg, act_next;
    logic [NW-1:0]                 src_reg, src_next, snk_reg, snk_next;
    logic [mcf_pkg::RES_W-1:0]     cap_reg, cap_next;
    logic [15:0]                   cst_reg, cst_next;
    logic [NW-1:0]                 idx_reg, idx_next;
    logic [XW-1:0]                 arc_cnt_reg, arc_cnt_next;
    logic [NW-1:0]                 rd_reg, rd_next;
    logic [mcf_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [mcf_pkg::POP_W-1:0]     pops_reg, pops_next;
    logic [NW-1:0]                 u_reg, u_next;
    logic [mcf_pkg::DIST_W-1:0]    du_reg, du_next;
    logic [XW-1:0]                 a_cur_reg, a_cur_next;
    logic [mcf_pkg::STEP_W-1:0]    steps_reg, steps_next;
    logic [mcf_pkg::DIST_W-1:0]    cost_reg, cost_next;
    logic [mcf_pkg::UNIT_W-1:0]    units_reg, units_next;
    logic [mcf_pkg::PUSH_W-1:0]    pushed_reg, pushed_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_status_reg, out_status_next;
    logic [mcf_pkg::DIST_W-1:0]    out_cost_reg, out_cost_next;
    logic [mcf_pkg::UNIT_W-1:0]    out_units_reg, out_units_next;

    // RAM ports
    logic                          arc_we, arc_re;
    logic [AW-1:0]                 arc_wa, arc_ra;
    mcf_pkg::arc_t                 arc_wd, arc_q;
    logic                          res_we, res_re;
    logic [AW-1:0]                 res_wa, res_ra;
    logic [mcf_pkg::RES_W-1:0]     res_wd, res_q;
    logic                          fst_we, fst_re;
    logic [NW-1:0]                 fst_wa, fst_ra;
    logic [XW-1:0]                 fst_wd, fst_q;
    logic                          dst_we, dst_re;
    logic [NW-1:0]                 dst_wa, dst_ra;
    logic [mcf_pkg::DIST_W-1:0]    dst_wd, dst_q;
    logic                          prd_we, prd_re;
    logic [NW-1:0]                 prd_wa, prd_ra;
    logic [XW-1:0]                 prd_wd, prd_q;
    logic                          qd_we, qd_re;
    logic [NW-1:0]                 qd_wa, qd_ra;
    logic [0:0]                    qd_wd, qd_q;
    logic                          ff_we, ff_re;
    logic [NW-1:0]                 ff_wa, ff_ra;
    logic [NW-1:0]                 ff_wd, ff_q;

    logic [mcf_pkg::DIST_W-1:0]    cand;
    logic                          relax;
    logic                          enq;
    logic [AW-1:0]                 k_lo;

    mcf_ram #(.W($bits(mcf_pkg::arc_t)), .D(mcf_pkg::MAX_ARCS)) u_arc (
        .clk(clk), .we(arc_we), .waddr(arc_wa), .wdata(arc_wd),
        .re(arc_re), .raddr(arc_ra), .rdata(arc_q));
    mcf_ram #(.W(mcf_pkg::RES_W), .D(mcf_pkg::MAX_ARCS)) u_res (
        .clk(clk), .we(res_we), .waddr(res_wa), .wdata(res_wd),
        .re(res_re), .raddr(res_ra), .rdata(res_q));
    mcf_ram #(.W(XW), .D(mcf_pkg::MAX_NODES)) u_first (
        .clk(clk), .we(fst_we), .waddr(fst_wa), .wdata(fst_wd),
        .re(fst_re), .raddr(fst_ra), .rdata(fst_q));
    mcf_ram #(.W(mcf_pkg::DIST_W), .D(mcf_pkg::MAX_NODES)) u_dist (
        .clk(clk), .we(dst_we), .waddr(dst_wa), .wdata(dst_wd),
        .re(dst_re), .raddr(dst_ra), .rdata(dst_q));
    mcf_ram #(.W(XW), .D(mcf_pkg::MAX_NODES)) u_pred (
        .clk(clk), .we(prd_we), .waddr(prd_wa), .wdata(prd_wd),
        .re(prd_re), .raddr(prd_ra), .rdata(prd_q));
    mcf_ram #(.W(1), .D(mcf_pkg::MAX_NODES)) u_queued (
        .clk(clk), .we(qd_we), .waddr(qd_wa), .wdata(qd_wd),
        .re(qd_re), .raddr(qd_ra), .rdata(qd_q));
    mcf_ram #(.W(NW), .D(mcf_pkg::MAX_NODES)) u_fifo (
        .clk(clk), .we(ff_we), .waddr(ff_wa), .wdata(ff_wd),
        .re(ff_re), .raddr(ff_ra), .rdata(ff_q));

    // arc_q and res_q hold the arc under scan until the next arc read
    assign cand  = du_reg + {{(mcf_pkg::DIST_W - mcf_pkg::WGT_W){arc_q.weight[16]}},
                             arc_q.weight};
    assign relax = (res_q != '0) && ($signed(dst_q) > $signed(cand));
    assign enq   = relax && !qd_q[0] && !cnt_reg[NW];
    assign k_lo  = arc_cnt_reg[AW-1:0];

    always_comb
    begin
        arc_we = 1'b0; arc_re = 1'b0; arc_wa = k_lo; arc_ra = a_cur_reg[AW-1:0];
        arc_wd = '{link: fst_q, weight: {1'b0, cst_reg}, head: snk_reg, tail: src_reg};
        res_we = 1'b0; res_re = 1'b0; res_wa = k_lo; res_ra = a_cur_reg[AW-1:0];
        res_wd = cap_reg;
        fst_we = 1'b0; fst_re = 1'b0; fst_wa = idx_reg; fst_ra = src_reg;
        fst_wd = mcf_pkg::NO_ARC;
        dst_we = 1'b0; dst_re = 1'b0; dst_wa = idx_reg; dst_ra = ff_q;
        dst_wd = mcf_pkg::DIST_INF;
        prd_we = 1'b0; prd_re = 1'b0; prd_wa = idx_reg; prd_ra = snk_reg;
        prd_wd = mcf_pkg::NO_ARC;
        qd_we  = 1'b0; qd_re  = 1'b0; qd_wa  = idx_reg; qd_ra  = arc_q.head;
        qd_wd  = 1'b0;
        ff_we  = 1'b0; ff_re  = 1'b0; ff_wa  = '0; ff_ra = rd_reg;
        ff_wd  = src_reg;
        case (cmd)
            mcf_pkg::C_SWEEP:
            begin
                fst_we = 1'b1;
                qd_we  = 1'b1;
            end
            mcf_pkg::C_ADD_RA:
            begin
                fst_re = 1'b1;
            end
            mcf_pkg::C_ADD_WA:
            begin
                arc_we = 1'b1;
                res_we = 1'b1;
                fst_we = 1'b1;
                fst_wa = src_reg;
                fst_wd = arc_cnt_reg;
            end
            mcf_pkg::C_ADD_RB:
            begin
                fst_re = 1'b1;
                fst_ra = snk_reg;
            end
            mcf_pkg::C_ADD_WB:
            begin
                arc_we = 1'b1;
                arc_wa = k_lo | AW'(1);
                arc_wd = '{link: fst_q, weight: 17'd0 - {1'b0, cst_reg},
                           head: src_reg, tail: snk_reg};
                res_we = 1'b1;
                res_wa = k_lo | AW'(1);
                res_wd = '0;
                fst_we = 1'b1;
                fst_wa = snk_reg;
                fst_wd = arc_cnt_reg | XW'(1);
            end
            mcf_pkg::C_SR_CLR:
            begin
                dst_we = 1'b1;
                prd_we = 1'b1;
                qd_we  = 1'b1;
            end
            mcf_pkg::C_SR_SRC:
            begin
                dst_we = 1'b1;
                dst_wa = src_reg;
                dst_wd = '0;
                prd_we = 1'b1;
                prd_wa = src_reg;
                qd_we  = 1'b1;
                qd_wa  = src_reg;
                qd_wd  = 1'b1;
                ff_we  = 1'b1;
            end
            mcf_pkg::C_POP, mcf_pkg::C_DRAIN_RD:
            begin
                ff_re = 1'b1;
            end
            mcf_pkg::C_U:
            begin
                fst_re = 1'b1;
                fst_ra = ff_q;
                dst_re = 1'b1;
                qd_we  = 1'b1;
                qd_wa  = ff_q;
            end
            mcf_pkg::C_ARC_RD, mcf_pkg::C_CHK_RD, mcf_pkg::C_PW_RD:
            begin
                arc_re = 1'b1;
                res_re = (cmd != mcf_pkg::C_CHK_RD);
            end
            mcf_pkg::C_A2:
            begin
                dst_re = 1'b1;
                dst_ra = arc_q.head;
                qd_re  = 1'b1;
            end
            mcf_pkg::C_RELAX:
            begin
                dst_we = relax;
                dst_wa = arc_q.head;
                dst_wd = cand;
                prd_we = relax;
                prd_wa = arc_q.head;
                prd_wd = a_cur_reg;
                qd_we  = relax && !qd_q[0];
                qd_wa  = arc_q.head;
                qd_wd  = 1'b1;
                ff_we  = enq;
                ff_wa  = rd_reg + cnt_reg[NW-1:0];
                ff_wd  = arc_q.head;
            end
            mcf_pkg::C_DRAIN_WR:
            begin
                qd_we = 1'b1;
                qd_wa = ff_q;
            end
            mcf_pkg::C_END_RD:
            begin
                dst_re = 1'b1;
                dst_ra = snk_reg;
            end
            mcf_pkg::C_AUG_RD:
            begin
                prd_re = 1'b1;
            end
            mcf_pkg::C_CHK_PRED:
            begin
                prd_re = 1'b1;
                prd_ra = arc_q.tail;
            end
            mcf_pkg::C_PW_DEC:
            begin
                res_we = 1'b1;
                res_wa = a_cur_reg[AW-1:0];
                res_wd = (res_q != '0) ? res_q - 16'd1 : '0;
                res_re = 1'b1;
                res_ra = a_cur_reg[AW-1:0] ^ AW'(1);
            end
            mcf_pkg::C_PW_INC:
            begin
                res_we = 1'b1;
                res_wa = a_cur_reg[AW-1:0] ^ AW'(1);
                res_wd = (res_q != '1) ? res_q + 16'd1 : res_q;
                prd_re = 1'b1;
                prd_ra = arc_q.tail;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        act_next        = act_reg;
        src_next        = src_reg;
        snk_next        = snk_reg;
        cap_next        = cap_reg;
        cst_next        = cst_reg;
        idx_next        = idx_reg;
        arc_cnt_next    = arc_cnt_reg;
        rd_next         = rd_reg;
        cnt_next        = cnt_reg;
        pops_next       = pops_reg;
        u_next          = u_reg;
        du_next         = du_reg;
        a_cur_next      = a_cur_reg;
        steps_next      = steps_reg;
        cost_next       = cost_reg;
        units_next      = units_reg;
        pushed_next     = pushed_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_cost_next   = out_cost_reg;
        out_units_next  = out_units_reg;
        case (cmd)
            mcf_pkg::C_LATCH:
            begin
                act_next = mcf_pkg::action_t'(s_tuser);
                src_next = s_tdata[9:0];
                snk_next = s_tdata[19:10];
                cap_next = s_tdata[35:20];
                cst_next = s_tdata[51:36];
                idx_next = '0;
            end
            mcf_pkg::C_SWEEP:
            begin
                idx_next     = idx_reg + NW'(1);
                arc_cnt_next = '0;
            end
            mcf_pkg::C_ADD_WB:
            begin
                arc_cnt_next = arc_cnt_reg + XW'(2);
            end
            mcf_pkg::C_SOLVE_INIT:
            begin
                cost_next   = '0;
                units_next  = '0;
                pushed_next = '0;
                idx_next    = '0;
            end
            mcf_pkg::C_SR_CLR:
            begin
                idx_next = idx_reg + NW'(1);
            end
            mcf_pkg::C_SR_SRC:
            begin
                rd_next   = '0;
                cnt_next  = CNT_ONE;
                pops_next = '0;
            end
            mcf_pkg::C_POP:
            begin
                rd_next   = rd_reg + NW'(1);
                cnt_next  = cnt_reg - CNT_ONE;
                pops_next = pops_reg + mcf_pkg::POP_W'(1);
            end
            mcf_pkg::C_DRAIN_RD:
            begin
                rd_next  = rd_reg + NW'(1);
                cnt_next = cnt_reg - CNT_ONE;
            end
            mcf_pkg::C_U:
            begin
                u_next = ff_q;
            end
            mcf_pkg::C_U2:
            begin
                a_cur_next = fst_q;
                du_next    = dst_q;
            end
            mcf_pkg::C_RELAX:
            begin
                // a self-loop may lower the distance of the node being scanned
                if (relax && (arc_q.head == u_reg))
                begin
                    du_next = cand;
                end
                if (enq)
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
                a_cur_next = arc_q.link;
            end
            mcf_pkg::C_AUG_P:
            begin
                a_cur_next = prd_q;
                steps_next = '0;
            end
            mcf_pkg::C_CHK_NEXT:
            begin
                a_cur_next = prd_q;
                steps_next = steps_reg + mcf_pkg::STEP_W'(1);
            end
            mcf_pkg::C_PW_DEC:
            begin
                cost_next = cost_reg + {{(mcf_pkg::DIST_W - mcf_pkg::WGT_W){arc_q.weight[16]}},
                                        arc_q.weight};
            end
            mcf_pkg::C_UNIT:
            begin
                pushed_next = pushed_reg + mcf_pkg::PUSH_W'(1);
                if (units_reg != '1)
                begin
                    units_next = units_reg + mcf_pkg::UNIT_W'(1);
                end
                idx_next = '0;
            end
            mcf_pkg::C_RES_SOLVE:
            begin
                out_valid_next  = 1'b1;
                out_status_next = 1'b0;
                out_cost_next   = cost_reg;
                out_units_next  = units_reg;
            end
            mcf_pkg::C_RES_FULL:
            begin
                out_valid_next  = 1'b1;
                out_status_next = 1'b1;
                out_cost_next   = '0;
                out_units_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            arc_cnt_reg   <= '0;
            rd_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            arc_cnt_reg   <= arc_cnt_next;
            rd_reg        <= rd_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        src_reg        <= src_next;
        snk_reg        <= snk_next;
        cap_reg        <= cap_next;
        cst_reg        <= cst_next;
        pops_reg       <= pops_next;
        u_reg          <= u_next;
        du_reg         <= du_next;
        a_cur_reg      <= a_cur_next;
        steps_reg      <= steps_next;
        cost_reg       <= cost_next;
        units_reg      <= units_next;
        pushed_reg     <= pushed_next;
        out_status_reg <= out_status_next;
        out_cost_reg   <= out_cost_next;
        out_units_reg  <= out_units_next;
    end

    always_comb
    begin
        st.act         = act_reg;
        st.sweep_last  = (idx_reg == '1);
        st.srclr_last  = (idx_reg == snk_reg);
        st.add_full    = (arc_cnt_reg >= mcf_pkg::ADD_FULL_AT);
        st.src_eq_snk  = (src_reg == snk_reg);
        st.fifo_empty  = (cnt_reg == '0);
        st.pop_over    = pops_reg[mcf_pkg::POP_W-1];
        st.arc_end     = a_cur_reg[XW-1];
        st.snk_reached = ($signed(dst_q) < $signed(mcf_pkg::DIST_INF));
        st.pred_none   = (prd_q == mcf_pkg::NO_ARC);
        st.a_none      = (a_cur_reg == mcf_pkg::NO_ARC);
        st.chain_bad   = a_cur_reg[XW-1] || steps_reg[mcf_pkg::STEP_W-1];
        st.unit_last   = (pushed_reg == mcf_pkg::UNIT_LAST);
        st.out_busy    = out_valid_reg && !m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_units_reg, out_cost_reg};
    assign m_tuser  = out_status_reg;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= mcf_pkg::CNT_W'(mcf_pkg::MAX_NODES))
        else $error("work queue count above depth");

    a_arc_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        !arc_cnt_reg[0] && (arc_cnt_reg <= XW'(mcf_pkg::MAX_ARCS)))
        else $error("arc count odd or beyond store");

    a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == mcf_pkg::C_RES_SOLVE || cmd == mcf_pkg::C_RES_FULL) |=> m_tvalid)
        else $error("result beat not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> (cmd != mcf_pkg::C_RES_SOLVE && cmd != mcf_pkg::C_RES_FULL))
        else $error("pending result overwritten");

endmodule

// ===== sv/min_cost_flow_spfa_unit.sv =====
`timescale 1ns / 1ps
// Min-cost max-flow engine, one unit per augmentation, queue-based shortest path.
// Clear sweeps the first-arc and queued tables. Add writes an arc and its reverse,
// or is dropped when the store is full. Solve: each search resets the node tables,
// pops nodes, scans arcs, checks the path and pushes a unit; simple dual-port RAMs.
// One item at a time; result beat is registered and may wait while the next item loads.
// Reset: sweep of first-arc and queued tables before the first beat is taken.
module min_cost_flow_spfa_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // from_node[9:0], to_node[19:10], capacity[35:20], arc_cost[51:36], zero pad
    input  logic [mcf_pkg::IN_DATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // total_cost[31:0], flow_units[47:32]
    output logic [mcf_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status[0]
    output logic [0:0]                      m_tuser
);

    mcf_pkg::cmd_t  cmd;
    mcf_pkg::stat_t st;

    mcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mcf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/min_cost_flow_spfa_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for min_cost_flow_spfa_unit: graph building, full store, random solves.
// Depends on mcf_pkg; keeps its own residual-graph flow solver to predict each result beat.
module min_cost_flow_spfa_unit_tb;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;
    // a runaway search may pop a million nodes with tens of arcs each
    localparam int   STALL_LIMIT = 1000000000;

    typedef struct packed {
        logic        status;
        logic [31:0] cost;
        logic [15:0] units;
    } flow_res_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [mcf_pkg::IN_DATA_W-1:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [mcf_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;

    min_cost_flow_spfa_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // shadow graph
    logic [mcf_pkg::NODE_W-1:0] g_head [mcf_pkg::MAX_ARCS];
    logic [mcf_pkg::NODE_W-1:0] g_tail [mcf_pkg::MAX_ARCS];
    logic [mcf_pkg::RES_W-1:0]  g_res  [mcf_pkg::MAX_ARCS];
    logic [mcf_pkg::WGT_W-1:0]  g_wgt  [mcf_pkg::MAX_ARCS];
    logic [mcf_pkg::ARC_W-1:0]  g_link [mcf_pkg::MAX_ARCS];
    logic [mcf_pkg::ARC_W-1:0]  g_first [mcf_pkg::MAX_NODES];
    logic [mcf_pkg::DIST_W-1:0] g_dist [mcf_pkg::MAX_NODES];
    logic [mcf_pkg::ARC_W-1:0]  g_pred [mcf_pkg::MAX_NODES];
    bit                         g_queued [mcf_pkg::MAX_NODES];
    int                         g_arcs;

    flow_res_t flow_expected[$];
    int  mismatches;
    bit  rx_hold_req;
    bit  tx_calm;
    int  stall_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // shortest residual path; returns 1 when the sink is reached
    function automatic bit find_path(input int src, input int snk);
        int q[$];
        longint pops;
        int u;
        int v;
        logic [mcf_pkg::ARC_W-1:0] a;
        logic [mcf_pkg::DIST_W-1:0] cand;
        pops = 0;
        for (int n = 0; n <= snk; n++)
        begin
            g_queued[n] = 0;
            g_dist[n] = mcf_pkg::DIST_INF;
            g_pred[n] = mcf_pkg::NO_ARC;
        end
        g_queued[src] = 1;
        g_dist[src] = '0;
        g_pred[src] = mcf_pkg::NO_ARC;
        q.push_back(src);
        while (q.size() > 0)
        begin
            if (pops >= longint'(mcf_pkg::MAX_NODES) * mcf_pkg::MAX_NODES)
            begin
                while (q.size() > 0)
                    g_queued[q.pop_front()] = 0;
                return 0;
            end
            pops++;
            u = q.pop_front();
            g_queued[u] = 0;
            a = g_first[u];
            while (a < mcf_pkg::MAX_ARCS)
            begin
                v = int'(g_head[a]);
                cand = g_dist[u] + {{(mcf_pkg::DIST_W-mcf_pkg::WGT_W){g_wgt[a][mcf_pkg::WGT_W-1]}},
                                    g_wgt[a]};
                if (g_res[a] != 0 && $signed(g_dist[v]) > $signed(cand))
                begin
                    g_dist[v] = cand;
                    g_pred[v] = a;
                    if (!g_queued[v])
                    begin
                        g_queued[v] = 1;
                        if (q.size() < mcf_pkg::MAX_NODES)
                            q.push_back(v);
                    end
                end
                a = g_link[a];
            end
        end
        return $signed(g_dist[snk]) < $signed(mcf_pkg::DIST_INF);
    endfunction

    function automatic flow_res_t run_flow(input int src, input int snk);
        flow_res_t r;
        longint pushed;
        logic [mcf_pkg::ARC_W-1:0] a;
        int steps;
        bit ok;
        r = '0;
        pushed = 0;
        if (src == snk)
            return r;
        while (pushed < longint'(mcf_pkg::MAX_ARCS / 2) * 65535 && find_path(src, snk))
        begin
            a = g_pred[snk];
            if (a == mcf_pkg::NO_ARC)
                return r;
            steps = 0;
            ok = 1;
            while (a != mcf_pkg::NO_ARC)
            begin
                if (a >= mcf_pkg::MAX_ARCS || steps >= mcf_pkg::MAX_NODES)
                begin
                    ok = 0;
                    break;
                end
                a = g_pred[g_tail[a]];
                steps++;
            end
            if (!ok)
                return r;
            for (a = g_pred[snk]; a != mcf_pkg::NO_ARC; a = g_pred[g_tail[a]])
            begin
                if (g_res[a] > 0)
                    g_res[a]--;
                if (g_res[a ^ 1] != 16'hffff)
                    g_res[a ^ 1]++;
                r.cost += {{(mcf_pkg::DIST_W-mcf_pkg::WGT_W){g_wgt[a][mcf_pkg::WGT_W-1]}},
                           g_wgt[a]};
            end
            pushed++;
            if (r.units != 16'hffff)
                r.units++;
        end
        return r;
    endfunction

    // applies one accepted beat to the shadow graph, queues any result it causes
    task automatic apply_beat(input mcf_pkg::action_t act, input int fa, input int ta,
                              input logic [15:0] cap, input logic [15:0] cst);
        flow_res_t r;
        case (act)
            mcf_pkg::ACT_CLEAR:
            begin
                foreach (g_first[n])
                    g_first[n] = mcf_pkg::NO_ARC;
                g_arcs = 0;
            end
            mcf_pkg::ACT_ADD:
            begin
                if (g_arcs + 2 > mcf_pkg::MAX_ARCS)
                begin
                    r = '0;
                    r.status = ST_FULL;
                    flow_expected.push_back(r);
                end
                else
                begin
                    g_tail[g_arcs] = fa[mcf_pkg::NODE_W-1:0];
                    g_head[g_arcs] = ta[mcf_pkg::NODE_W-1:0];
                    g_res[g_arcs] = cap;
                    g_wgt[g_arcs] = {1'b0, cst};
                    g_link[g_arcs] = g_first[fa];
                    g_first[fa] = g_arcs[mcf_pkg::ARC_W-1:0];
                    g_tail[g_arcs+1] = ta[mcf_pkg::NODE_W-1:0];
                    g_head[g_arcs+1] = fa[mcf_pkg::NODE_W-1:0];
                    g_res[g_arcs+1] = '0;
                    g_wgt[g_arcs+1] = -{1'b0, cst};
                    g_link[g_arcs+1] = g_first[ta];
                    g_first[ta] = g_arcs[mcf_pkg::ARC_W-1:0] + mcf_pkg::ARC_W'(1);
                    g_arcs += 2;
                end
            end
            mcf_pkg::ACT_SOLVE:
            begin
                r = run_flow(fa, ta);
                r.status = ST_DONE;
                flow_expected.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(input mcf_pkg::action_t act, input int fa, input int ta,
                             input int cap = 0, input int cst = 0);
        if (!tx_calm && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, cst[15:0], cap[15:0], ta[9:0], fa[9:0]};
        do
            @(posedge clk);
        while (!s_tready);
        apply_beat(act, fa, ta, cap[15:0], cst[15:0]);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (flow_expected.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    // result beats: checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (flow_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d cost %0d units %0d",
                             m_tuser[0], $signed(m_tdata[31:0]), m_tdata[47:32]);
            end
            else
            begin
                flow_res_t e;
                e = flow_expected.pop_front();
                if (e.status !== m_tuser[0] || e.cost !== m_tdata[31:0]
                    || e.units !== m_tdata[47:32])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat differs: exp status %0d cost %0d units %0d, got %0d %0d %0d",
                                 e.status, $signed(e.cost), e.units, m_tuser[0],
                                 $signed(m_tdata[31:0]), m_tdata[47:32]);
                end
            end
        end
    end

    // receiver stalls, with one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                rx_hold_req = 0;
            end
            m_tready <= tx_calm ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("min_cost_flow_spfa_unit: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        // first solve to the top node visits every node's distance entry
        send_beat(mcf_pkg::ACT_SOLVE, 0, 1023);
        send_beat(mcf_pkg::ACT_ADD, 0, 1, 2, 5);
        send_beat(mcf_pkg::ACT_ADD, 1, 3, 1, 65535);
        send_beat(mcf_pkg::ACT_ADD, 0, 2, 65535, 0);
        send_beat(mcf_pkg::ACT_ADD, 2, 3, 1, 0);
        send_beat(mcf_pkg::ACT_ADD, 1, 2, 0, 7);
        send_beat(mcf_pkg::ACT_ADD, 3, 900, 65535, 12);
        send_beat(mcf_pkg::ACT_ADD, 1023, 0, 0, 65535);
        send_beat(mcf_pkg::ACT_NONE, 1023, 1023, 65535, 65535);
        send_beat(mcf_pkg::ACT_SOLVE, 0, 3);
        send_beat(mcf_pkg::ACT_SOLVE, 0, 3);
        send_beat(mcf_pkg::ACT_SOLVE, 2, 2);
        send_beat(mcf_pkg::ACT_SOLVE, 5, 3);
        send_beat(mcf_pkg::ACT_ADD, 3, 0, 3, 1);
        send_beat(mcf_pkg::ACT_SOLVE, 3, 2);
        send_beat(mcf_pkg::ACT_SOLVE, 1023, 0);
        send_beat(mcf_pkg::ACT_CLEAR, 0, 0);
        send_beat(mcf_pkg::ACT_SOLVE, 0, 3);
    endtask

    task automatic test_store_full();
        send_beat(mcf_pkg::ACT_CLEAR, 0, 0);
        for (int i = 0; i < mcf_pkg::MAX_ARCS / 2 + 2; i++)
            send_beat(mcf_pkg::ACT_ADD, 1000, 1001, 0, i);
        send_beat(mcf_pkg::ACT_SOLVE, 0, 3);
        send_beat(mcf_pkg::ACT_CLEAR, 0, 0);
    endtask

    task automatic test_random(input int total);
        int sent;
        int k;
        int top;
        bit pressed;
        sent = 0;
        pressed = 0;
        while (sent < total)
        begin
            tx_calm = ($urandom_range(9) == 0);
            send_beat(mcf_pkg::ACT_CLEAR, 0, 0);
            sent++;
            top = $urandom_range(1) ? 7 : 15;
            k = $urandom_range(4, 30);
            for (int i = 0; i < k; i++)
            begin
                int r;
                r = $urandom_range(99);
                if (r < 8)
                    send_beat(mcf_pkg::ACT_ADD, $urandom_range(top), $urandom_range(900, 1022),
                              $urandom_range(65535), $urandom_range(65535));
                else if (r < 12)
                    send_beat(mcf_pkg::ACT_NONE, $urandom_range(1023), $urandom_range(1023),
                              $urandom_range(65535), $urandom_range(65535));
                else if (r < 20)
                    send_beat(mcf_pkg::ACT_SOLVE, $urandom_range(top), $urandom_range(top));
                else
                    send_beat(mcf_pkg::ACT_ADD, $urandom_range(top), $urandom_range(top),
                              $urandom_range(3),
                              $urandom_range(3) == 0 ? $urandom_range(65535)
                                                     : $urandom_range(20));
                sent++;
            end
            if (!pressed && sent > total / 2)
            begin
                // receiver holds off while solves keep coming
                pressed = 1;
                rx_hold_req = 1;
                for (int i = 0; i < 5; i++)
                    send_beat(mcf_pkg::ACT_SOLVE, $urandom_range(top), $urandom_range(top));
                sent += 5;
                drain_results();
            end
            for (int i = $urandom_range(1, 3); i > 0; i--)
            begin
                send_beat(mcf_pkg::ACT_SOLVE, $urandom_range(top),
                          $urandom_range(49) == 0 ? 1023 : $urandom_range(top));
                sent++;
            end
        end
        tx_calm = 0;
    endtask

    initial begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = mcf_pkg::ACT_NONE;
        mismatches = 0;
        rx_hold_req = 0;
        tx_calm = 0;
        stall_cycles = 0;
        g_arcs = 0;
        foreach (g_first[n])
        begin
            g_first[n] = mcf_pkg::NO_ARC;
            g_pred[n] = mcf_pkg::NO_ARC;
            g_dist[n] = '0;
            g_queued[n] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_store_full();
        // the full-store fill alone takes over two thousand beats
        test_random(120);
        drain_results();
        if (mismatches == 0)
            $display("min_cost_flow_spfa_unit: match");
        else
            $display("min_cost_flow_spfa_unit: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/mcf_pkg.sv
sv/mcf_ram.sv
sv/mcf_ctrl.sv
sv/mcf_dp.sv
sv/min_cost_flow_spfa_unit.sv
tb/min_cost_flow_spfa_unit_tb.sv
